@@ design/qmr_pkg.sv @@
// package for the quaternion multiply / rotate core
// shared quaternion type, operation codes and fixed-point helpers; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qmr_pkg;

	localparam int unsigned Q_W           = 32;
	localparam int unsigned PROD_W        = 2 * Q_W;
	localparam int unsigned FRAC_BITS_DEF = 16;

	typedef enum logic {
		OP_PRODUCT = 1'b0,
		OP_ROTATE  = 1'b1
	} op_t;

	typedef struct packed {
		logic signed [Q_W-1:0] r;
		logic signed [Q_W-1:0] x;
		logic signed [Q_W-1:0] y;
		logic signed [Q_W-1:0] z;
	} quat_t;

	localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

	// exact signed product of two q values
	function automatic logic signed [PROD_W-1:0] mul_q(
		input logic signed [Q_W-1:0] a,
		input logic signed [Q_W-1:0] b
	);
		mul_q = PROD_W'(a) * PROD_W'(b);
	endfunction

	// negate with saturation, most negative value maps to max
	function automatic logic signed [Q_W-1:0] neg_sat(input logic signed [Q_W-1:0] v);
		if (v == Q_MIN) begin
			neg_sat = Q_MAX;
		end else begin
			neg_sat = -v;
		end
	endfunction

endpackage

`default_nettype wire

@@ design/qmr_hamilton.sv @@
// three-stage pipelined fixed-point hamilton product c = a*b with saturation
// depends on qmr_pkg; carries a sideband word alongside each beat
`timescale 1ns / 1ps
`default_nettype none

module qmr_hamilton #(
	parameter int unsigned FRAC_BITS = qmr_pkg::FRAC_BITS_DEF,
	parameter int unsigned SIDE_W    = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  qmr_pkg::quat_t      a,
	input  qmr_pkg::quat_t      b,
	input  logic [SIDE_W-1:0]   side_in,
	output logic                out_valid,
	input  logic                out_ready,
	output qmr_pkg::quat_t      c,
	output logic [SIDE_W-1:0]   side_out
);
	import qmr_pkg::*;

	// truncated term width, pair sum width, full sum width
	localparam int unsigned TW = PROD_W - FRAC_BITS;
	localparam int unsigned PW = TW + 1;
	localparam int unsigned SW = TW + 2;
	localparam logic signed [SW-1:0] SAT_HI = SW'(Q_MAX);
	localparam logic signed [SW-1:0] SAT_LO = SW'(Q_MIN);

	logic                      v_s1, v_s2, v_s3;
	logic                      rdy1, rdy2, rdy3;
	logic signed [PROD_W-1:0]  prod_s1 [4][4];
	logic signed [PW-1:0]      pair_s2 [4][2];
	logic signed [TW-1:0]      term    [4][4];
	logic signed [PW-1:0]      pair_d  [4][2];
	logic signed [SW-1:0]      sum_d   [4];
	logic signed [Q_W-1:0]     sat_d   [4];
	logic [SIDE_W-1:0]         side_s1, side_s2, side_s3;
	quat_t                     c_s3;

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// stage 1: sixteen products, row per output component
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			prod_s1[0][0] <= mul_q(b.r, a.r);
			prod_s1[0][1] <= mul_q(a.x, b.x);
			prod_s1[0][2] <= mul_q(a.y, b.y);
			prod_s1[0][3] <= mul_q(a.z, b.z);
			prod_s1[1][0] <= mul_q(a.x, b.r);
			prod_s1[1][1] <= mul_q(b.x, a.r);
			prod_s1[1][2] <= mul_q(a.y, b.z);
			prod_s1[1][3] <= mul_q(a.z, b.y);
			prod_s1[2][0] <= mul_q(a.y, b.r);
			prod_s1[2][1] <= mul_q(b.y, a.r);
			prod_s1[2][2] <= mul_q(a.z, b.x);
			prod_s1[2][3] <= mul_q(a.x, b.z);
			prod_s1[3][0] <= mul_q(a.z, b.r);
			prod_s1[3][1] <= mul_q(b.z, a.r);
			prod_s1[3][2] <= mul_q(a.x, b.y);
			prod_s1[3][3] <= mul_q(a.y, b.x);
			side_s1       <= side_in;
		end
	end

	// stage 2: floor shift back to q format, then pairwise sums
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			for (int j = 0; j < 4; j++) begin
				term[k][j] = TW'(prod_s1[k][j] >>> FRAC_BITS);
			end
		end
		// real part subtracts the dot product
		pair_d[0][0] = PW'(term[0][0]) - PW'(term[0][1]);
		pair_d[0][1] = -PW'(term[0][2]) - PW'(term[0][3]);
		for (int k = 1; k < 4; k++) begin
			pair_d[k][0] = PW'(term[k][0]) + PW'(term[k][1]);
			pair_d[k][1] = PW'(term[k][2]) - PW'(term[k][3]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			pair_s2 <= pair_d;
			side_s2 <= side_s1;
		end
	end

	// stage 3: final add and saturate
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sum_d[k] = SW'(pair_s2[k][0]) + SW'(pair_s2[k][1]);
			if (sum_d[k] > SAT_HI) begin
				sat_d[k] = Q_MAX;
			end else if (sum_d[k] < SAT_LO) begin
				sat_d[k] = Q_MIN;
			end else begin
				sat_d[k] = Q_W'(sum_d[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			c_s3.r  <= sat_d[0];
			c_s3.x  <= sat_d[1];
			c_s3.y  <= sat_d[2];
			c_s3.z  <= sat_d[3];
			side_s3 <= side_s2;
		end
	end

	assign out_valid = v_s3;
	assign c         = c_s3;
	assign side_out  = side_s3;

endmodule

`default_nettype wire

@@ design/quaternion_multiply_rotate_core.sv @@
// top level of the fixed-point quaternion product / rotation core
// depends on qmr_pkg and qmr_hamilton (two chained product pipelines)
`timescale 1ns / 1ps
`default_nettype none

// Quaternion unit on signed fixed-point values (FRAC_BITS fraction bits, Q16.16
// by default). operation 0 returns the Hamilton product q*b; operation 1 rotates
// the point (b_x, b_y, b_z) by q as conj(q)*p*q and returns the rotated vector
// with result_real forced to zero. Every product is floored back to Q format and
// each component saturates to the 32-bit range, the intermediate conj(q)*p too.
// The core takes one beat per clock unless out_ready stalls it, and holds no
// state between beats. Each beat passes two hamilton pipelines of three stages
// each (multiply, shift and pair add, final add and saturate). For a plain
// product the second pipeline multiplies by the unit quaternion, which passes
// the first result through unchanged. Each stage has its own ready, so bubbles
// close up while the output beat waits and a stall drops or repeats nothing.

module quaternion_multiply_rotate_core #(
	parameter int unsigned FRAC_BITS = qmr_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              operation,
	input  logic signed [qmr_pkg::Q_W-1:0]    q_real,
	input  logic signed [qmr_pkg::Q_W-1:0]    q_x,
	input  logic signed [qmr_pkg::Q_W-1:0]    q_y,
	input  logic signed [qmr_pkg::Q_W-1:0]    q_z,
	input  logic signed [qmr_pkg::Q_W-1:0]    b_real,
	input  logic signed [qmr_pkg::Q_W-1:0]    b_x,
	input  logic signed [qmr_pkg::Q_W-1:0]    b_y,
	input  logic signed [qmr_pkg::Q_W-1:0]    b_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [qmr_pkg::Q_W-1:0]    result_real,
	output logic signed [qmr_pkg::Q_W-1:0]    result_x,
	output logic signed [qmr_pkg::Q_W-1:0]    result_y,
	output logic signed [qmr_pkg::Q_W-1:0]    result_z
);
	import qmr_pkg::*;

	localparam int unsigned QB_W   = $bits(quat_t);
	localparam int unsigned SIDE_W = 1 + QB_W;

	// unit quaternion 1.0 in the chosen q format
	localparam logic signed [Q_W-1:0] Q_ONE =
		{{(Q_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

	quat_t             q_in, a1, b1, c1, q_mid, a2, b2, c2;
	logic              rot_in, rot_mid, rot_out;
	logic [SIDE_W-1:0] side1_in, side1_out;
	logic              v1, r1;

	assign rot_in = (op_t'(operation) == OP_ROTATE);
	assign q_in   = '{r: q_real, x: q_x, y: q_y, z: q_z};

	// first pass: q*b, or conj(q)*p with a pure-vector point
	always_comb begin
		if (rot_in) begin
			a1 = '{r: q_real, x: neg_sat(q_x), y: neg_sat(q_y), z: neg_sat(q_z)};
			b1 = '{r: '0, x: b_x, y: b_y, z: b_z};
		end else begin
			a1 = q_in;
			b1 = '{r: b_real, x: b_x, y: b_y, z: b_z};
		end
	end

	assign side1_in = {rot_in, q_in};

	qmr_hamilton #(
		.FRAC_BITS (FRAC_BITS),
		.SIDE_W    (SIDE_W)
	) u_pass1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.a         (a1),
		.b         (b1),
		.side_in   (side1_in),
		.out_valid (v1),
		.out_ready (r1),
		.c         (c1),
		.side_out  (side1_out)
	);

	assign rot_mid = side1_out[SIDE_W-1];
	assign q_mid   = quat_t'(side1_out[QB_W-1:0]);

	// second pass: (conj(q)*p)*q for rotate, times unit for product
	assign a2 = c1;
	always_comb begin
		if (rot_mid) begin
			b2 = q_mid;
		end else begin
			b2 = '{r: Q_ONE, x: '0, y: '0, z: '0};
		end
	end

	qmr_hamilton #(
		.FRAC_BITS (FRAC_BITS),
		.SIDE_W    (1)
	) u_pass2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r1),
		.a         (a2),
		.b         (b2),
		.side_in   (rot_mid),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.c         (c2),
		.side_out  (rot_out)
	);

	// rotate drops the real part
	assign result_real = rot_out ? '0 : c2.r;
	assign result_x    = c2.x;
	assign result_y    = c2.y;
	assign result_z    = c2.z;

endmodule

`default_nettype wire

@@ dv/qmr_checker.sv @@
// checker for the quaternion multiply / rotate core: watches both channels,
// predicts each result and compares it; depends on qmr_pkg
`timescale 1ns / 1ps

module qmr_checker #(
	parameter int unsigned FRAC_BITS = qmr_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic                           operation,
	input  logic signed [qmr_pkg::Q_W-1:0] q_real,
	input  logic signed [qmr_pkg::Q_W-1:0] q_x,
	input  logic signed [qmr_pkg::Q_W-1:0] q_y,
	input  logic signed [qmr_pkg::Q_W-1:0] q_z,
	input  logic signed [qmr_pkg::Q_W-1:0] b_real,
	input  logic signed [qmr_pkg::Q_W-1:0] b_x,
	input  logic signed [qmr_pkg::Q_W-1:0] b_y,
	input  logic signed [qmr_pkg::Q_W-1:0] b_z,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic signed [qmr_pkg::Q_W-1:0] result_real,
	input  logic signed [qmr_pkg::Q_W-1:0] result_x,
	input  logic signed [qmr_pkg::Q_W-1:0] result_y,
	input  logic signed [qmr_pkg::Q_W-1:0] result_z,
	output int                             errors,
	output int                             pending
);

	import qmr_pkg::*;

	quat_t expected_results[$];
	int    fail_count = 0;
	int    waiting    = 0;

	assign errors  = fail_count;
	assign pending = waiting;

	// exact product floored back to q format
	function automatic longint floor_mul(input logic signed [Q_W-1:0] a,
		input logic signed [Q_W-1:0] b);
		longint full;
		full = longint'(a) * longint'(b);
		return full >>> FRAC_BITS;
	endfunction

	function automatic logic signed [Q_W-1:0] clamp_q(input longint v);
		if (v > longint'(Q_MAX)) begin
			return Q_MAX;
		end else if (v < longint'(Q_MIN)) begin
			return Q_MIN;
		end
		return v[Q_W-1:0];
	endfunction

	function automatic quat_t ham_product(input quat_t a, input quat_t b);
		logic signed [Q_W-1:0] ar, ax, ay, az, br, bx, by, bz;
		quat_t c;
		ar = a.r; ax = a.x; ay = a.y; az = a.z;
		br = b.r; bx = b.x; by = b.y; bz = b.z;
		c.r = clamp_q(floor_mul(br, ar) - floor_mul(ax, bx) - floor_mul(ay, by)
			- floor_mul(az, bz));
		c.x = clamp_q(floor_mul(ax, br) + floor_mul(bx, ar) + floor_mul(ay, bz)
			- floor_mul(az, by));
		c.y = clamp_q(floor_mul(ay, br) + floor_mul(by, ar) + floor_mul(az, bx)
			- floor_mul(ax, bz));
		c.z = clamp_q(floor_mul(az, br) + floor_mul(bz, ar) + floor_mul(ax, by)
			- floor_mul(ay, bx));
		return c;
	endfunction

	function automatic quat_t predict_result(input op_t op, input quat_t q, input quat_t b);
		logic signed [Q_W-1:0] vx, vy, vz;
		quat_t q_conj, point, half;
		quat_t res;
		if (op == OP_ROTATE) begin
			vx = q.x; vy = q.y; vz = q.z;
			// conjugate saturates, so the most negative component turns into max
			q_conj.r = q.r;
			q_conj.x = clamp_q(-longint'(vx));
			q_conj.y = clamp_q(-longint'(vy));
			q_conj.z = clamp_q(-longint'(vz));
			point    = b;
			point.r  = '0;
			half     = ham_product(q_conj, point);
			res      = ham_product(half, q);
			res.r    = '0;
		end else begin
			res = ham_product(q, b);
		end
		return res;
	endfunction

	task automatic check_field(input string name, input logic signed [Q_W-1:0] exp_v,
		input logic signed [Q_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $realtime, name,
				exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		quat_t exp_q;
		quat_t q_in, b_in;
		if (!arst_n) begin
			expected_results.delete();
			waiting = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display({"%0t: result beat with nothing expected,",
						" expected none actual %h %h %h %h"},
						$realtime, result_real, result_x, result_y, result_z);
					fail_count++;
				end else begin
					exp_q = expected_results.pop_front();
					check_field("result_real", exp_q.r, result_real);
					check_field("result_x", exp_q.x, result_x);
					check_field("result_y", exp_q.y, result_y);
					check_field("result_z", exp_q.z, result_z);
				end
			end
			if (in_valid && in_ready) begin
				q_in = '{r: q_real, x: q_x, y: q_y, z: q_z};
				b_in = '{r: b_real, x: b_x, y: b_y, z: b_z};
				expected_results.push_back(predict_result(op_t'(operation), q_in, b_in));
			end
			waiting = expected_results.size();
		end
	end

endmodule

@@ dv/tb_quaternion_multiply_rotate_core.sv @@
// testbench top for quaternion_multiply_rotate_core: drives product and rotate
// beats with random idling on both sides; depends on qmr_pkg and qmr_checker
`timescale 1ns / 1ps

module tb_quaternion_multiply_rotate_core;

	import qmr_pkg::*;

	localparam int          RANDOM_BEATS = 1835;
	localparam int          DRAIN_CYCLES = 30;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;

	// handy q16.16 values
	localparam logic signed [Q_W-1:0] ONE   = 32'sd65536;
	localparam logic signed [Q_W-1:0] M_ONE = -32'sd65536;
	localparam logic signed [Q_W-1:0] C45   = 32'sd46341;  // cos/sin of 45 degrees
	localparam logic signed [Q_W-1:0] ZERO  = '0;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic                  operation = 1'b0;
	logic signed [Q_W-1:0] q_real    = '0;
	logic signed [Q_W-1:0] q_x       = '0;
	logic signed [Q_W-1:0] q_y       = '0;
	logic signed [Q_W-1:0] q_z       = '0;
	logic signed [Q_W-1:0] b_real    = '0;
	logic signed [Q_W-1:0] b_x       = '0;
	logic signed [Q_W-1:0] b_y       = '0;
	logic signed [Q_W-1:0] b_z       = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic signed [Q_W-1:0] result_real;
	logic signed [Q_W-1:0] result_x;
	logic signed [Q_W-1:0] result_y;
	logic signed [Q_W-1:0] result_z;

	int          errors;
	int          pending;
	int unsigned cycle_count = 0;
	bit          tx_steady   = 1'b0;  // sender runs back to back while set
	bit          rx_steady   = 1'b0;  // receiver never stalls while set

	quaternion_multiply_rotate_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.q_real     (q_real),
		.q_x        (q_x),
		.q_y        (q_y),
		.q_z        (q_z),
		.b_real     (b_real),
		.b_x        (b_x),
		.b_y        (b_y),
		.b_z        (b_z),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result_real(result_real),
		.result_x   (result_x),
		.result_y   (result_y),
		.result_z   (result_z)
	);

	// predictor and scoreboard live beside the core
	qmr_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.q_real     (q_real),
		.q_x        (q_x),
		.q_y        (q_y),
		.q_z        (q_z),
		.b_real     (b_real),
		.b_x        (b_x),
		.b_y        (b_y),
		.b_z        (b_z),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result_real(result_real),
		.result_x   (result_x),
		.result_y   (result_y),
		.result_z   (result_z),
		.errors     (errors),
		.pending    (pending)
	);

	// 12 ns clock
	initial begin
		forever begin
			#6 clk = ~clk;
		end
	end

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_quaternion_multiply_rotate_core NOT OK");
			$finish;
		end
	end

	// idle length: mostly zero or short, now and then long
	function automatic int idle_cycles();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			return 0;
		end else if (pick < 85) begin
			return $urandom_range(1, 3);
		end else if (pick < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic quat_t mk_quat(input logic signed [Q_W-1:0] r,
		input logic signed [Q_W-1:0] x, input logic signed [Q_W-1:0] y,
		input logic signed [Q_W-1:0] z);
		quat_t v;
		v.r = r; v.x = x; v.y = y; v.z = z;
		return v;
	endfunction

	// one fixed-point component, spread over full range, small values,
	// unit range, boundaries and the rails
	function automatic logic signed [Q_W-1:0] rand_component();
		logic signed [Q_W-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				v = $urandom();
			end
			4, 5: begin
				v = 32'($urandom_range(0, 262144)) - 32'sd131072;
			end
			6: begin
				case ($urandom_range(0, 6))
					0: v = Q_MAX;
					1: v = Q_MIN;
					2: v = ZERO;
					3: v = 32'sd1;
					4: v = -32'sd1;
					5: v = ONE;
					default: v = M_ONE;
				endcase
			end
			7: begin
				v = 32'($urandom_range(0, 131072)) - 32'sd65536;
			end
			8: begin
				v = $urandom();
				v = v >>> $urandom_range(0, 31);
			end
			default: begin
				if ($urandom_range(0, 1)) begin
					v = Q_MAX - 32'($urandom_range(0, 255));
				end else begin
					v = Q_MIN + 32'($urandom_range(0, 255));
				end
			end
		endcase
		return v;
	endfunction

	function automatic quat_t rand_quat();
		return mk_quat(rand_component(), rand_component(), rand_component(),
			rand_component());
	endfunction

	// present one beat and hold it until the core takes it; valid is left high
	task automatic send_beat(input op_t op, input quat_t q, input quat_t b);
		in_valid  <= 1'b1;
		operation <= op;
		q_real    <= q.r;
		q_x       <= q.x;
		q_y       <= q.y;
		q_z       <= q.z;
		b_real    <= b.r;
		b_x       <= b.x;
		b_y       <= b.y;
		b_z       <= b.z;
		do begin
			@(posedge clk);
		end while (!in_ready);
	endtask

	// gap after an accepted beat, unless the sender is in a steady stretch
	task automatic sender_gap();
		int gap;
		gap = tx_steady ? 0 : idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_and_gap(input op_t op, input quat_t q, input quat_t b);
		send_beat(op, q, b);
		sender_gap();
	endtask

	// receiver side: ready held for a while, then stalls of random length
	initial begin
		int hold;
		int stall;
		@(posedge clk);
		forever begin
			hold = $urandom_range(1, 24);
			out_ready <= 1'b1;
			repeat (hold) @(posedge clk);
			if ($urandom_range(0, 15) == 0) begin
				rx_steady = !rx_steady;
			end
			stall = rx_steady ? 0 : idle_cycles();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin
		quat_t q, b;
		op_t   op;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: zeros, identity and basis products
		send_and_gap(OP_PRODUCT, mk_quat(ZERO, ZERO, ZERO, ZERO),
			mk_quat(ZERO, ZERO, ZERO, ZERO));
		send_and_gap(OP_PRODUCT, mk_quat(ONE, ZERO, ZERO, ZERO),
			mk_quat(32'sd12345, -32'sd98765, 32'sd7, M_ONE));
		// i * j = k, and j * i = -k
		send_and_gap(OP_PRODUCT, mk_quat(ZERO, ONE, ZERO, ZERO),
			mk_quat(ZERO, ZERO, ONE, ZERO));
		send_and_gap(OP_PRODUCT, mk_quat(ZERO, ZERO, ONE, ZERO),
			mk_quat(ZERO, ONE, ZERO, ZERO));
		// rails drive every component into saturation
		send_and_gap(OP_PRODUCT, mk_quat(Q_MAX, Q_MAX, Q_MAX, Q_MAX),
			mk_quat(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
		send_and_gap(OP_PRODUCT, mk_quat(Q_MIN, Q_MIN, Q_MIN, Q_MIN),
			mk_quat(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
		send_and_gap(OP_PRODUCT, mk_quat(Q_MAX, Q_MIN, Q_MAX, Q_MIN),
			mk_quat(Q_MIN, Q_MAX, Q_MIN, Q_MAX));
		// tiny negative products floor toward minus infinity
		send_and_gap(OP_PRODUCT, mk_quat(-32'sd1, 32'sd1, -32'sd1, 32'sd3),
			mk_quat(32'sd1, 32'sd1, 32'sd1, -32'sd5));
		send_and_gap(OP_PRODUCT, mk_quat(-32'sd32769, 32'sd65535, -32'sd2, 32'sd1),
			mk_quat(32'sd3, -32'sd1, 32'sd65535, -32'sd65537));
		send_and_gap(OP_PRODUCT, mk_quat(ZERO, Q_MIN, ZERO, ZERO),
			mk_quat(Q_MAX, ZERO, ZERO, ZERO));

		// directed rotations: identity, 90 degrees about z, zero q
		send_and_gap(OP_ROTATE, mk_quat(ONE, ZERO, ZERO, ZERO),
			mk_quat(ZERO, 32'sd131072, -32'sd65536, 32'sd40000));
		send_and_gap(OP_ROTATE, mk_quat(C45, ZERO, ZERO, C45),
			mk_quat(ZERO, ONE, ZERO, ZERO));
		send_and_gap(OP_ROTATE, mk_quat(ZERO, ZERO, ZERO, ZERO),
			mk_quat(Q_MAX, Q_MAX, Q_MIN, Q_MAX));
		// b_real is ignored for a rotation
		send_and_gap(OP_ROTATE, mk_quat(C45, C45, ZERO, ZERO),
			mk_quat(Q_MIN, ZERO, ONE, M_ONE));
		// most negative vector part: the conjugate saturates to max
		send_and_gap(OP_ROTATE, mk_quat(ONE, Q_MIN, Q_MIN, Q_MIN),
			mk_quat(ZERO, ONE, ONE, ONE));
		send_and_gap(OP_ROTATE, mk_quat(ZERO, Q_MIN, ZERO, ZERO),
			mk_quat(ZERO, ZERO, 32'sd1, ZERO));
		// intermediate and final saturation on the rails
		send_and_gap(OP_ROTATE, mk_quat(Q_MAX, Q_MAX, Q_MAX, Q_MAX),
			mk_quat(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
		send_and_gap(OP_ROTATE, mk_quat(Q_MIN, Q_MIN, Q_MIN, Q_MIN),
			mk_quat(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
		send_and_gap(OP_ROTATE, mk_quat(Q_MIN, Q_MAX, Q_MIN, Q_MAX),
			mk_quat(ZERO, Q_MIN, Q_MAX, Q_MIN));
		send_and_gap(OP_ROTATE, mk_quat(-32'sd1, 32'sd1, -32'sd1, 32'sd1),
			mk_quat(ZERO, -32'sd1, 32'sd1, -32'sd1));

		// random part: mixed operations, steady and bursty stretches on both sides
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if ($urandom_range(0, 120) == 0) begin
				tx_steady = !tx_steady;
			end
			op = $urandom_range(0, 1) ? OP_ROTATE : OP_PRODUCT;
			q  = rand_quat();
			b  = rand_quat();
			send_beat(op, q, b);
			if (n == RANDOM_BEATS - 1) begin
				in_valid <= 1'b0;
			end else begin
				sender_gap();
			end
		end

		// let the pipeline drain, then give the verdict
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0) begin
			$display("tb_quaternion_multiply_rotate_core OK");
		end else begin
			$display("tb_quaternion_multiply_rotate_core NOT OK");
		end
		$finish;
	end

endmodule
